@@ sv/radix_digit_converter_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the radix digit converter
// Concurrent assertion wrappers shared by the converter's modules.
// ---------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_CORE_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rdc_pkg.sv @@
// ---------------------------------------------------------------------------
// rdc_pkg
// Types and constants shared by the radix digit converter modules.
// ---------------------------------------------------------------------------
package rdc_pkg;

    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 7;
    localparam int M_TDATA_W = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
    localparam logic [CHAR_W-1:0] ASCII_F    = 7'd70;
    localparam logic [CHAR_W-1:0] DIGIT_TEN  = 7'd10;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new value and radix, clear the chain
        logic step;   // shift one value bit into the digit chain
        logic skip;   // discard a leading zero digit
        logic take;   // move the top digit into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bits_done;  // the final value bit is being shifted in
        logic top_zero;   // the top digit of the chain is zero
        logic rem_one;    // exactly one digit is left in the chain
        logic overflow;   // the number has more digits than the chain holds
        logic out_last;   // the output register holds the final digit
    } sts_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] digit);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, digit};
        if (d_ext < DIGIT_TEN) begin
            return ASCII_ZERO + d_ext;
        end
        return ASCII_A + (d_ext - DIGIT_TEN);
    endfunction

endpackage

@@ sv/rdc_ctrl.sv @@
// ---------------------------------------------------------------------------
// rdc_ctrl
// Controller: sequences loading, bit conversion, leading-zero skipping and
// digit emission.
// ---------------------------------------------------------------------------
`include "radix_digit_converter_core_assert.svh"

module rdc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  rdc_pkg::sts_t sts,
    output rdc_pkg::cmd_t cmd
);

    rdc_pkg::state_t state_reg;
    rdc_pkg::state_t state_next;

    assign s_tready = (state_reg == rdc_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == rdc_pkg::ST_EMIT);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            rdc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = rdc_pkg::ST_CONV;
                end
            end
            rdc_pkg::ST_CONV: begin
                cmd.step = 1'b1;
                if (sts.bits_done) begin
                    state_next = rdc_pkg::ST_SKIP;
                end
            end
            rdc_pkg::ST_SKIP: begin
                // Leading zeros are dropped, down to a single digit, unless the number
                // was cut short, in which case every stored digit is sent.
                if (!sts.overflow && sts.top_zero && !sts.rem_one) begin
                    cmd.skip = 1'b1;
                end else begin
                    cmd.take   = 1'b1;
                    state_next = rdc_pkg::ST_EMIT;
                end
            end
            rdc_pkg::ST_EMIT: begin
                if (m_tready) begin
                    if (sts.out_last) begin
                        state_next = rdc_pkg::ST_IDLE;
                    end else begin
                        cmd.take = 1'b1;
                    end
                end
            end
            default: begin
                state_next = rdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rdc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `RDC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted again before the conversion started")
    `RDC_ASSERT_NEXT(a_idle_after_last, aclk, aresetn, m_tvalid && m_tready && sts.out_last, s_tready, "not idle after the final digit transaction")

endmodule

@@ sv/rdc_datapath.sv @@
// ---------------------------------------------------------------------------
// rdc_datapath
// Datapath: a chain of digit cells that absorbs the value one bit per cycle,
// most significant bit first, followed by the digit output register.
// ---------------------------------------------------------------------------
`include "radix_digit_converter_core_assert.svh"

module rdc_datapath #(
    parameter int VALUE_BITS = 63,
    parameter int MAX_DIGITS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [VALUE_BITS-1:0]               in_value,
    input  logic [rdc_pkg::RADIX_W-1:0]         in_radix,
    input  rdc_pkg::cmd_t                       cmd,
    output rdc_pkg::sts_t                       sts,
    output logic [rdc_pkg::CHAR_W-1:0]          out_char,
    output logic                                out_last
);

    localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
    localparam int REM_W     = $clog2(MAX_DIGITS + 1);
    localparam int DW        = rdc_pkg::DIGIT_W;
    localparam int RW        = rdc_pkg::RADIX_W;

    logic [VALUE_BITS-1:0] value_reg;
    logic [RW-1:0]         radix_reg;
    logic [RW-1:0]         radix_sat;
    logic [DW-1:0]         cell_reg  [MAX_DIGITS];
    logic [DW-1:0]         cell_next [MAX_DIGITS];
    logic [RW-1:0]         cell_diff [MAX_DIGITS];
    logic                  overflow_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [rdc_pkg::CHAR_W-1:0] char_reg;
    logic                  last_reg;

    logic [MAX_DIGITS-1:0] gen_vec;
    logic [MAX_DIGITS-1:0] prop_vec;
    logic [MAX_DIGITS:0]   add_a;
    logic [MAX_DIGITS:0]   add_b;
    logic [MAX_DIGITS:0]   add_sum;
    logic [MAX_DIGITS:0]   carry_vec;
    logic                  bit_in;
    logic [DW-1:0]         top_digit;
    logic [RW-1:0]         top_digit_ext;

    always_comb begin
        priority if (in_radix < rdc_pkg::RADIX_MIN) begin
            radix_sat = rdc_pkg::RADIX_MIN;
        end else if (in_radix > rdc_pkg::RADIX_MAX) begin
            radix_sat = rdc_pkg::RADIX_MAX;
        end else begin
            radix_sat = in_radix;
        end
    end

    assign bit_in        = value_reg[VALUE_BITS-1];
    assign top_digit     = cell_reg[MAX_DIGITS-1];
    assign top_digit_ext = {1'b0, top_digit};

    // Each cell doubles its digit and adds the carry from below. A cell sends
    // a carry up when twice its digit reaches the radix (generate) or when
    // twice its digit plus one equals the radix and a carry comes in
    // (propagate). The carries are resolved by one wide addition.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            gen_vec[i]  = ({cell_reg[i], 1'b0} >= radix_reg);
            prop_vec[i] = ({cell_reg[i], 1'b1} == radix_reg);
        end
    end

    assign add_a     = {1'b0, gen_vec | prop_vec};
    assign add_b     = {1'b0, gen_vec};
    assign add_sum   = add_a + add_b + {{MAX_DIGITS{1'b0}}, bit_in};
    assign carry_vec = add_sum ^ add_a ^ add_b;

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            cell_diff[i] = {cell_reg[i], carry_vec[i]}
                         - (carry_vec[i+1] ? radix_reg : {RW{1'b0}});
            cell_next[i] = cell_diff[i][DW-1:0];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= in_value;
            radix_reg <= radix_sat;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                cell_reg[i] <= '0;
            end
        end else if (cmd.step) begin
            value_reg <= {value_reg[VALUE_BITS-2:0], 1'b0};
            for (int i = 0; i < MAX_DIGITS; i++) begin
                cell_reg[i] <= cell_next[i];
            end
        end else if (cmd.skip || cmd.take) begin
            cell_reg[0] <= '0;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                cell_reg[i] <= cell_reg[i-1];
            end
        end
        if (cmd.take) begin
            char_reg <= rdc_pkg::digit_to_ascii(top_digit);
            last_reg <= (rem_reg == REM_W'(1));
        end
    end

    // Counters and the overflow flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overflow_reg <= 1'b0;
            bit_cnt_reg  <= '0;
            rem_reg      <= '0;
        end else if (cmd.load) begin
            overflow_reg <= 1'b0;
            bit_cnt_reg  <= BIT_CNT_W'(VALUE_BITS);
            rem_reg      <= REM_W'(MAX_DIGITS);
        end else if (cmd.step) begin
            overflow_reg <= overflow_reg | add_sum[MAX_DIGITS];
            bit_cnt_reg  <= bit_cnt_reg - BIT_CNT_W'(1);
        end else if (cmd.skip || cmd.take) begin
            rem_reg <= rem_reg - REM_W'(1);
        end
    end

    assign sts.bits_done = (bit_cnt_reg == BIT_CNT_W'(1));
    assign sts.top_zero  = (top_digit == '0);
    assign sts.rem_one   = (rem_reg == REM_W'(1));
    assign sts.overflow  = overflow_reg;
    assign sts.out_last  = last_reg;

    assign out_char = char_reg;
    assign out_last = last_reg;

    `RDC_ASSERT_NEXT(a_digit_char_range, aclk, aresetn, cmd.take, out_char >= rdc_pkg::ASCII_ZERO && out_char <= rdc_pkg::ASCII_F, "digit character outside 0-9 and A-F")
    `RDC_ASSERT_NEXT(a_top_digit_below_radix, aclk, aresetn, cmd.step, top_digit_ext < radix_reg, "top digit cell not below the radix")

endmodule

@@ sv/radix_digit_converter_core.sv @@
// ---------------------------------------------------------------------------
// radix_digit_converter_core
// Converts a non-negative integer into its digits in a base from 2 to 16 and
// sends them as uppercase ASCII characters, most significant first.
// ---------------------------------------------------------------------------
//
//   Channel   Direction   Contents
//   s_*       in          value and radix of one number
//   m_*       out         one ASCII digit, tlast on the least significant
//
// A number is loaded, its bits are shifted into the digit cell chain, each
// leading zero cell is dropped, the leading digit is moved into the output
// register and then the digits are sent one by one, most significant first.
// The one-bit-per-cycle shift into the cell chain sets the conversion time.
// s_tready is high only while the core is idle; a low m_tready holds the
// current digit. aresetn is synchronous; the digit cells are not cleared.
// ---------------------------------------------------------------------------
module radix_digit_converter_core #(
    parameter int VALUE_BITS = 63,
    parameter int MAX_DIGITS = 64,
    localparam int S_TDATA_W = ((VALUE_BITS + rdc_pkg::RADIX_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_TDATA_W-1:0]          s_tdata,   // value, radix
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rdc_pkg::M_TDATA_W-1:0] m_tdata,   // digit_char
    output logic                          m_tlast
);

    rdc_pkg::cmd_t                 cmd;
    rdc_pkg::sts_t                 sts;
    logic [rdc_pkg::CHAR_W-1:0]    out_char;

    rdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rdc_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_value (s_tdata[VALUE_BITS-1:0]),
        .in_radix (s_tdata[VALUE_BITS +: rdc_pkg::RADIX_W]),
        .cmd      (cmd),
        .sts      (sts),
        .out_char (out_char),
        .out_last (m_tlast)
    );

    assign m_tdata = {{(rdc_pkg::M_TDATA_W - rdc_pkg::CHAR_W){1'b0}}, out_char};

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for radix_digit_converter_core
// Sends numbers with a base on the input stream and checks every ASCII
// digit that comes back, most significant first with tlast on the final one,
// against digits worked out here by repeated division. Both stream sides
// pause at random. At one point the receiver holds off for a long stretch so
// that the core backs up into its input.
// ---------------------------------------------------------------------------
module testbench;

    localparam int VALUE_BITS  = 63;
    localparam int S_TDATA_W   = ((VALUE_BITS + rdc_pkg::RADIX_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_LEN    = 3000;
    localparam int HOLD_AFTER  = 400;
    localparam int RANDOM_ITEMS = 450;

    typedef struct packed {
        logic [VALUE_BITS-1:0]       value;
        logic [rdc_pkg::RADIX_W-1:0] radix;
    } number_t;

    typedef struct packed {
        logic [rdc_pkg::CHAR_W-1:0] digit_char;
        logic                       last_digit;
    } digit_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [rdc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    number_t pending_numbers[$];
    digit_t  expected_digits[$];
    number_t number_on_bus;

    int numbers_sent   = 0;
    int digits_checked = 0;
    int errors         = 0;
    int cycle_count    = 0;
    int send_wait      = 0;
    int send_quiet     = 0;
    int recv_wait      = 0;
    int recv_quiet     = 0;
    int hold_cycles    = 0;
    bit hold_done      = 1'b0;
    logic hold_active  = 1'b0;

    radix_digit_converter_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // Divides the value down, least significant digit first, and queues the
    // resulting characters in sending order.
    task automatic convert_to_digits(input number_t num);
        logic [63:0] rest;
        logic [63:0] base;
        logic [3:0]  digits[$];
        logic [rdc_pkg::CHAR_W-1:0] ch;
        digit_t      d;
        rest = {1'b0, num.value};
        base = {59'd0, num.radix};
        if (base < 64'(rdc_pkg::RADIX_MIN)) begin
            base = 64'(rdc_pkg::RADIX_MIN);
        end else if (base > 64'(rdc_pkg::RADIX_MAX)) begin
            base = 64'(rdc_pkg::RADIX_MAX);
        end
        do begin
            digits.push_front(4'(rest % base));
            rest = rest / base;
        end while (rest != 0);
        while (digits.size() != 0) begin
            ch = {3'd0, digits[0]};
            if (ch < rdc_pkg::DIGIT_TEN) begin
                d.digit_char = rdc_pkg::ASCII_ZERO + ch;
            end else begin
                d.digit_char = rdc_pkg::ASCII_A + ch - rdc_pkg::DIGIT_TEN;
            end
            void'(digits.pop_front());
            d.last_digit = (digits.size() == 0);
            expected_digits.push_back(d);
        end
    endtask

    // Random pauses, broken now and then by a run with none at all.
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Input side: one number per transaction, held until the core takes it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                convert_to_digits(number_on_bus);
                numbers_sent++;
                send_wait = draw_wait(send_quiet);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_numbers.size() != 0) begin
                    number_on_bus = pending_numbers.pop_front();
                    s_tdata  <= {{(S_TDATA_W - VALUE_BITS - rdc_pkg::RADIX_W){1'b0}},
                                 number_on_bus.radix, number_on_bus.value};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: compares each digit with the oldest one still expected.
    always @(posedge aclk) begin
        digit_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected digit: digit_char %0d last_digit %0d",
                           m_tdata[rdc_pkg::CHAR_W-1:0], m_tlast);
                    errors++;
                end else begin
                    want = expected_digits.pop_front();
                    if (m_tdata[rdc_pkg::CHAR_W-1:0] !== want.digit_char) begin
                        $error("digit_char: expected %0d, got %0d",
                               want.digit_char, m_tdata[rdc_pkg::CHAR_W-1:0]);
                        errors++;
                    end
                    if (m_tlast !== want.last_digit) begin
                        $error("last_digit: expected %0d, got %0d",
                               want.last_digit, m_tlast);
                        errors++;
                    end
                end
                digits_checked++;
                recv_wait = draw_wait(recv_quiet);
            end
            if (hold_active) begin
                m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // One long stall of the receiver part way through, so that the core
    // fills up and stops accepting while numbers are still on offer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_active <= 1'b0;
        end else if (!hold_done && digits_checked >= HOLD_AFTER) begin
            if (hold_cycles >= HOLD_LEN) begin
                hold_done = 1'b1;
                hold_active <= 1'b0;
            end else begin
                hold_cycles++;
                hold_active <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("radix_digit_converter_core: mismatch");
            $finish;
        end
    end

    initial begin
        logic [VALUE_BITS-1:0] all_ones;
        logic [63:0]           raw;
        number_t               num;
        all_ones = '1;

        // Directed numbers: zero, the widest value, bases outside 2..16 and
        // the letters at either end of the digit range.
        pending_numbers.push_back('{value: '0, radix: 5'd10});
        pending_numbers.push_back('{value: '0, radix: 5'd0});
        pending_numbers.push_back('{value: all_ones, radix: 5'd2});
        pending_numbers.push_back('{value: all_ones, radix: 5'd16});
        pending_numbers.push_back('{value: all_ones, radix: 5'd31});
        pending_numbers.push_back('{value: 63'd6, radix: 5'd1});
        pending_numbers.push_back('{value: 63'd255, radix: 5'd17});
        pending_numbers.push_back('{value: 63'd1, radix: 5'd16});
        pending_numbers.push_back('{value: 63'hAF, radix: 5'd16});
        for (int r = 3; r <= 15; r++) begin
            pending_numbers.push_back('{value: all_ones >> r, radix: 5'(r)});
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            raw = {$urandom, $urandom};
            num.value = raw[VALUE_BITS-1:0] >> $urandom_range(0, VALUE_BITS - 1);
            if ($urandom_range(0, 19) == 0) begin
                num.value = '0;
            end
            if ($urandom_range(0, 9) == 0) begin
                num.radix = 5'($urandom_range(0, 31));
            end else begin
                num.radix = 5'($urandom_range(2, 16));
            end
            pending_numbers.push_back(num);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_numbers.size() != 0 || s_tvalid || expected_digits.size() != 0) begin
            @(posedge aclk);
        end
        // Leave room for any stray digit the core might still send.
        repeat (200) @(posedge aclk);

        $display("converted %0d numbers into %0d digits over %0d cycles",
                 numbers_sent, digits_checked, cycle_count);
        $display("receiver held off once for %0d cycles", hold_cycles);
        if (errors == 0) begin
            $display("radix_digit_converter_core: match");
        end else begin
            $display("radix_digit_converter_core: mismatch");
        end
        $finish;
    end

endmodule
